// File: hw/rtl/tsw_pkg.sv
package tsw_pkg;

    localparam int ADDR_W     = 16;
    localparam int COORD_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int TEXEL_W    = 4 * CHAN_W;
    localparam int SUM_W      = 11;
    localparam int CNT_W      = 3;
    localparam int NBR_N      = 5;
    localparam int IDX_W      = 3;
    localparam int REG_W      = 9;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] REG_FILTER_MODE = 3'd0;
    localparam logic [2:0] REG_WRAP_S      = 3'd1;
    localparam logic [2:0] REG_WRAP_T      = 3'd2;
    localparam logic [2:0] REG_TEX_WIDTH   = 3'd3;
    localparam logic [2:0] REG_TEX_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_HAS_ALPHA   = 3'd5;

    localparam logic [IDX_W-1:0] NBR_CENTRE = 3'd0;
    localparam logic [IDX_W-1:0] NBR_LEFT   = 3'd1;
    localparam logic [IDX_W-1:0] NBR_RIGHT  = 3'd2;
    localparam logic [IDX_W-1:0] NBR_UP     = 3'd3;
    localparam logic [IDX_W-1:0] NBR_DOWN   = 3'd4;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [TEXEL_W-1:0] wdata;
    } mem_req_t;

    // truncating mean for one to five texels, constant reciprocals
    function automatic logic [CHAN_W-1:0] div_cnt(input logic [SUM_W-1:0] sum,
                                                  input logic [CNT_W-1:0] cnt);
        logic [21:0] p3;
        logic [23:0] p5;
        logic [CHAN_W-1:0] q;
        p3 = 22'(sum) * 22'(683);
        p5 = 24'(sum) * 24'(3277);
        case (cnt)
            3'd1: q = sum[7:0];
            3'd2: q = sum[8:1];
            3'd3: q = p3[18:11];
            3'd4: q = sum[9:2];
            3'd5: q = p5[21:14];
            default: q = sum[7:0];
        endcase
        return q;
    endfunction

endpackage

// File: hw/rtl/tsw_mul.sv
module tsw_mul
    import tsw_pkg::*;
#(
    parameter int A_W = 9,
    parameter int B_W = 17,
    parameter int C_W = 16,
    parameter int P_W = 27
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    input  logic [C_W-1:0] c,
    output logic [P_W-1:0] p
);

    logic [P_W-1:0] p_reg;

    // shared multiply-add, product registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= P_W'(a) * P_W'(b) + P_W'(c);
        end
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/tsw_texmem.sv
module tsw_texmem
    import tsw_pkg::*;
(
    input  logic               clk,
    input  mem_req_t           req,
    output logic [TEXEL_W-1:0] rdata
);

    logic [TEXEL_W-1:0] mem [2**ADDR_W];
    logic [TEXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        else
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/texture_sampler_wrap_filter.sv
// a write transaction updates the texel memory at the edge that accepts it
// a sample takes three passes through the shared multiply-add unit, five read slots on
// the single-ported texel memory and a division step before its result is loaded
// s_axis_tready stays low while a sample is in flight or its result cannot be loaded
// reset (rst_n, async, active low) clears control state and config registers;
// texel memory content is undefined until written
module texture_sampler_wrap_filter
    import tsw_pkg::*;
#(
    parameter int MAX_SIDE        = 256,
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // s_coord, t_coord, write_index, write_red, write_green, write_blue, write_alpha
    input  logic [95:0]           s_axis_tdata,
    // operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red, green, blue, alpha
    output logic [31:0]           m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int FRAC = COORD_FRAC_BITS;
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int U_W  = FRAC + 1;
    localparam int BW   = (U_W > SW) ? U_W : SW;
    localparam int CW   = (FRAC > SW) ? FRAC : SW;
    localparam int PW   = SW + BW + 1;
    localparam int WW   = (U_W > COORD_W) ? U_W : COORD_W;
    localparam int RW   = ((REG_W > SW) ? REG_W : SW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULX,
        S_MULY,
        S_MULC,
        S_RD,
        S_LAST,
        S_DIV
    } state_t;

    // config registers
    logic             filter_mode_reg;
    logic             wrap_s_reg;
    logic             wrap_t_reg;
    logic [REG_W-1:0] tex_width_reg;
    logic [REG_W-1:0] tex_height_reg;
    logic             has_alpha_reg;
    logic             apb_wr;
    logic [2:0]       apb_idx;

    assign pready  = 1'b1;
    assign apb_idx = paddr[4:2];
    assign apb_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= 1'b0;
            wrap_s_reg      <= 1'b1;
            wrap_t_reg      <= 1'b1;
            tex_width_reg   <= REG_W'(1);
            tex_height_reg  <= REG_W'(1);
            has_alpha_reg   <= 1'b1;
        end
        else if (apb_wr)
        begin
            case (apb_idx)
                REG_FILTER_MODE: filter_mode_reg <= pwdata[0];
                REG_WRAP_S:      wrap_s_reg      <= pwdata[0];
                REG_WRAP_T:      wrap_t_reg      <= pwdata[0];
                REG_TEX_WIDTH:   tex_width_reg   <= pwdata[REG_W-1:0];
                REG_TEX_HEIGHT:  tex_height_reg  <= pwdata[REG_W-1:0];
                REG_HAS_ALPHA:   has_alpha_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (apb_idx)
            REG_FILTER_MODE: prdata = APB_DATA_W'(filter_mode_reg);
            REG_WRAP_S:      prdata = APB_DATA_W'(wrap_s_reg);
            REG_WRAP_T:      prdata = APB_DATA_W'(wrap_t_reg);
            REG_TEX_WIDTH:   prdata = APB_DATA_W'(tex_width_reg);
            REG_TEX_HEIGHT:  prdata = APB_DATA_W'(tex_height_reg);
            REG_HAS_ALPHA:   prdata = APB_DATA_W'(has_alpha_reg);
            default:         prdata = '0;
        endcase
    end

    // coordinate wrap: negative or above one folds by repeat or clamp
    function automatic logic [U_W-1:0] wrap_coord(input logic [COORD_W-1:0] raw,
                                                  input logic rep);
        logic [WW-1:0] raw_ext;
        logic [WW-1:0] one_ext;
        logic [WW-1:0] frac;
        logic [WW-1:0] res;
        raw_ext = WW'(raw);
        one_ext = WW'(1) << FRAC;
        frac    = raw_ext & (one_ext - WW'(1));
        if (raw[COORD_W-1])
        begin
            res = rep ? frac : '0;
        end
        else if (raw_ext > one_ext)
        begin
            res = rep ? frac : one_ext;
        end
        else
        begin
            res = raw_ext;
        end
        return U_W'(res);
    endfunction

    function automatic logic [SW-1:0] eff_side(input logic [REG_W-1:0] r);
        logic [RW-1:0] rx;
        logic [SW-1:0] res;
        rx = RW'(r);
        if (rx == '0)
        begin
            res = SW'(1);
        end
        else if (rx > RW'(MAX_SIDE))
        begin
            res = SW'(MAX_SIDE);
        end
        else
        begin
            res = SW'(rx);
        end
        return res;
    endfunction

    // datapath state
    state_t             state_reg,  state_next;
    logic               mode_reg,   mode_next;
    logic [U_W-1:0]     u_reg,      u_next;
    logic [U_W-1:0]     v_reg,      v_next;
    logic [SW-1:0]      w_reg,      w_next;
    logic [SW-1:0]      h_reg,      h_next;
    logic [SW-1:0]      x_reg,      x_next;
    logic [SW-1:0]      y_reg,      y_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]   sum_reg  [4];
    logic [SUM_W-1:0]   sum_next [4];
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg,  out_data_next;

    // shared unit and memory
    logic               mul_en;
    logic [SW-1:0]      mul_a;
    logic [BW-1:0]      mul_b;
    logic [CW-1:0]      mul_c;
    logic [PW-1:0]      mul_p;
    mem_req_t           mem_req;
    logic [TEXEL_W-1:0] mem_rdata;

    logic [ADDR_W-1:0]  centre;
    logic [ADDR_W-1:0]  w16;
    logic [ADDR_W-1:0]  nbr_addr;
    logic [NBR_N-1:0]   nbr_en;
    logic               s_fire;

    tsw_mul #(
        .A_W (SW),
        .B_W (BW),
        .C_W (CW),
        .P_W (PW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .c   (mul_c),
        .p   (mul_p)
    );

    tsw_texmem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign centre = ADDR_W'(mul_p);
    assign w16    = ADDR_W'(w_reg);

    always_comb
    begin
        nbr_en[NBR_CENTRE] = 1'b1;
        nbr_en[NBR_LEFT]   = mode_reg && (x_reg != '0);
        nbr_en[NBR_RIGHT]  = mode_reg && (x_reg < (w_reg - SW'(1)));
        nbr_en[NBR_UP]     = mode_reg && (y_reg != '0);
        nbr_en[NBR_DOWN]   = mode_reg && (y_reg < (h_reg - SW'(1)));
        case (idx_reg)
            NBR_CENTRE: nbr_addr = centre;
            NBR_LEFT:   nbr_addr = centre - ADDR_W'(1);
            NBR_RIGHT:  nbr_addr = centre + ADDR_W'(1);
            NBR_UP:     nbr_addr = centre - w16;
            NBR_DOWN:   nbr_addr = centre + w16;
            default:    nbr_addr = centre;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        for (int c = 0; c < 4; c++)
        begin
            sum_next[c] = sum_reg[c];
        end

        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        mul_c  = '0;

        mem_req.we    = 1'b0;
        mem_req.addr  = nbr_addr;
        mem_req.wdata = s_axis_tdata[95:64];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // accumulate the texel read in the previous cycle
        if (rd_pend_reg)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sum_next[c] = sum_reg[c] + SUM_W'(mem_rdata[c*CHAN_W +: CHAN_W]);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tuser == OP_WRITE)
                    begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = s_axis_tdata[63:48];
                    end
                    else
                    begin
                        mode_next  = filter_mode_reg;
                        u_next     = wrap_coord(s_axis_tdata[23:0], wrap_s_reg);
                        v_next     = wrap_coord(s_axis_tdata[47:24], wrap_t_reg);
                        w_next     = eff_side(tex_width_reg);
                        h_next     = eff_side(tex_height_reg);
                        state_next = S_MULX;
                    end
                end
            end
            S_MULX:
            begin
                mul_en = 1'b1;
                mul_a  = w_reg - SW'(1);
                mul_b  = BW'(u_reg);
                mul_c  = mode_reg ? '0 : (CW'(1) << (FRAC - 1));
                for (int c = 0; c < 4; c++)
                begin
                    sum_next[c] = '0;
                end
                cnt_next   = '0;
                idx_next   = NBR_CENTRE;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                x_next     = mul_p[FRAC +: SW];
                mul_en     = 1'b1;
                mul_a      = h_reg - SW'(1);
                mul_b      = BW'(v_reg);
                mul_c      = mode_reg ? '0 : (CW'(1) << (FRAC - 1));
                state_next = S_MULC;
            end
            S_MULC:
            begin
                y_next     = mul_p[FRAC +: SW];
                mul_en     = 1'b1;
                mul_a      = mul_p[FRAC +: SW];
                mul_b      = BW'(w_reg);
                mul_c      = CW'(x_reg);
                state_next = S_RD;
            end
            S_RD:
            begin
                if (nbr_en[idx_reg])
                begin
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (idx_reg == NBR_DOWN)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    for (int c = 0; c < 4; c++)
                    begin
                        out_data_next[c*CHAN_W +: CHAN_W] = div_cnt(sum_reg[c], cnt_reg);
                    end
                    if (!has_alpha_reg)
                    begin
                        out_data_next[31:24] = 8'hFF;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        for (int c = 0; c < 4; c++)
        begin
            sum_reg[c] <= sum_next[c];
        end
    end

    // texel writes only happen between samples
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == S_IDLE))
        else $error("texel write during a sample");

    // the mean covers one to five texels, exactly one in nearest mode
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ((cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_W'(NBR_N))
                                  && (mode_reg || (cnt_reg == CNT_W'(1)))))
        else $error("texel count out of range");

    // no read may be left unaccumulated once the sequencer is ready again
    a_no_pend_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !rd_pend_reg)
        else $error("texel read pending while ready");

    // a loaded result comes from the division step
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_DIV))
        else $error("result loaded outside the division step");

endmodule

// File: tb/texture_sampler_wrap_filter_tb.sv
`timescale 1ns / 1ps

module texture_sampler_wrap_filter_tb;

    import tsw_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int SIDE_MAX      = 256;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 35;
    localparam int FIXED_PHASES  = 8;
    localparam int RANDOM_PHASES = 2;
    localparam int DIRECTED_ROWS = 13;
    localparam int EDGE_COORDS   = 11;

    localparam logic FILTER_NEAREST = 1'b0;
    localparam logic FILTER_AVERAGE = 1'b1;
    localparam logic WRAP_CLAMP     = 1'b0;
    localparam logic WRAP_REPEAT    = 1'b1;

    localparam longint unsigned COORD_ONE  = 64'd1 << FRAC_BITS;
    localparam longint unsigned COORD_HALF = 64'd1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    typedef struct packed {
        rgba_t       texel;
        logic [15:0] index;
        logic [23:0] t;
        logic [23:0] s;
    } texel_cmd_t;

    typedef struct packed {
        logic [2:0]       n;
        logic [4:0][15:0] a;
    } footprint_t;

    typedef struct packed {
        logic  fixed;
        rgba_t color;
    } pinned_color_t;

    typedef struct packed {
        logic       filter;
        logic       wrap_s;
        logic       wrap_t;
        logic [8:0] width;
        logic [8:0] height;
        logic       alpha;
    } tex_cfg_t;

    typedef struct packed {
        logic        op;
        logic [23:0] s;
        logic [23:0] t;
        logic [15:0] index;
        logic [31:0] texel;
        logic        fixed;
        logic [31:0] want;
    } directed_row_t;

    // texture is 1x1 after reset, so every sample returns texel 0
    localparam directed_row_t DIRECTED_TBL [DIRECTED_ROWS] = '{
        '{OP_WRITE,  24'h000000, 24'h000000, 16'h0000, 32'h00000000, 1'b0, 32'h0},
        '{OP_SAMPLE, 24'h000000, 24'h000000, 16'h0000, 32'h00000000, 1'b1, 32'h00000000},
        '{OP_WRITE,  24'h000000, 24'h000000, 16'h0000, 32'hFFFFFFFF, 1'b0, 32'h0},
        '{OP_SAMPLE, 24'h7FFFFF, 24'h800000, 16'h0000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{OP_WRITE,  24'h000000, 24'h000000, 16'hFFFF, 32'h12345678, 1'b0, 32'h0},
        '{OP_SAMPLE, 24'h010000, 24'h010000, 16'h0000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{OP_WRITE,  24'h000000, 24'h000000, 16'h0000, 32'h78563412, 1'b0, 32'h0},
        '{OP_SAMPLE, 24'hFF0000, 24'h020000, 16'h0000, 32'h00000000, 1'b1, 32'h78563412},
        '{OP_SAMPLE, 24'h008000, 24'hFF8000, 16'h0000, 32'h00000000, 1'b1, 32'h78563412},
        '{OP_WRITE,  24'h000000, 24'h000000, 16'h0000, 32'h3CC35AA5, 1'b0, 32'h0},
        '{OP_SAMPLE, 24'h800000, 24'h7FFFFF, 16'h0000, 32'h00000000, 1'b1, 32'h3CC35AA5},
        '{OP_WRITE,  24'h000000, 24'h000000, 16'h0001, 32'h00FF00FF, 1'b0, 32'h0},
        '{OP_SAMPLE, 24'hFFFFFF, 24'h00FFFF, 16'h0000, 32'h00000000, 1'b1, 32'h3CC35AA5}
    };

    localparam tex_cfg_t PHASE_TBL [FIXED_PHASES] = '{
        '{FILTER_NEAREST, WRAP_CLAMP,  WRAP_CLAMP,  9'd4,   9'd3,   1'b1},
        '{FILTER_AVERAGE, WRAP_REPEAT, WRAP_REPEAT, 9'd5,   9'd7,   1'b0},
        '{FILTER_AVERAGE, WRAP_CLAMP,  WRAP_REPEAT, 9'd256, 9'd256, 1'b1},
        '{FILTER_NEAREST, WRAP_REPEAT, WRAP_CLAMP,  9'd0,   9'd300, 1'b1},
        '{FILTER_AVERAGE, WRAP_REPEAT, WRAP_CLAMP,  9'd511, 9'd0,   1'b0},
        '{FILTER_NEAREST, WRAP_REPEAT, WRAP_REPEAT, 9'd256, 9'd256, 1'b0},
        '{FILTER_AVERAGE, WRAP_CLAMP,  WRAP_CLAMP,  9'd2,   9'd2,   1'b1},
        '{FILTER_AVERAGE, WRAP_REPEAT, WRAP_REPEAT, 9'd1,   9'd1,   1'b1}
    };

    localparam logic [23:0] EDGE_COORD_TBL [EDGE_COORDS] = '{
        24'h000000, 24'h010000, 24'h00FFFF, 24'h008000, 24'h010001, 24'h020000,
        24'hFF0000, 24'hFF8000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [95:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_WRITE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  cfg_filter = FILTER_NEAREST;
    logic                  cfg_wrap_s = WRAP_REPEAT;
    logic                  cfg_wrap_t = WRAP_REPEAT;
    logic [8:0]            cfg_width  = 9'd1;
    logic [8:0]            cfg_height = 9'd1;
    logic                  cfg_alpha  = 1'b1;

    logic [31:0]           texel_mem   [65536];
    bit                    texel_known [65536];
    rgba_t                 expected_colors [$];
    pinned_color_t         pinned_colors [$];

    int                    error_cnt     = 0;
    int                    burst_left    = 0;
    int                    writes_sent   = 0;
    int                    samples_sent  = 0;
    int                    colors_seen   = 0;
    int                    phases_run    = 0;
    int unsigned           cycle_cnt     = 0;
    logic [11:0]           rx_tick       = '0;

    texture_sampler_wrap_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern: always ready, light, heavy, then long stalls
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1'b1;
        case (rx_tick[11:10])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= ($urandom_range(0, 1) == 0);
            default: m_axis_tready <= (rx_tick[4:0] > 5'd24);
        endcase
    end

    function automatic longint unsigned side_of(logic [8:0] raw);
        if (raw == 9'd0)
            return 1;
        if (raw > SIDE_MAX)
            return SIDE_MAX;
        return raw;
    endfunction

    function automatic longint unsigned wrap_coord(logic [23:0] raw, logic mode);
        longint unsigned frac;
        frac = longint'(raw) & (COORD_ONE - 1);
        if (raw[23])
            return (mode == WRAP_REPEAT) ? frac : 0;
        if (longint'(raw) > COORD_ONE)
            return (mode == WRAP_REPEAT) ? frac : COORD_ONE;
        return raw;
    endfunction

    function automatic footprint_t texel_footprint(logic [23:0] s, logic [23:0] t);
        footprint_t      fp;
        longint unsigned w;
        longint unsigned h;
        longint unsigned u;
        longint unsigned v;
        longint unsigned x;
        longint unsigned y;
        longint unsigned c;
        w = side_of(cfg_width);
        h = side_of(cfg_height);
        u = wrap_coord(s, cfg_wrap_s);
        v = wrap_coord(t, cfg_wrap_t);
        fp = '0;
        if (cfg_filter == FILTER_NEAREST)
        begin
            x = ((w - 1) * u + COORD_HALF) >> FRAC_BITS;
            y = ((h - 1) * v + COORD_HALF) >> FRAC_BITS;
            fp.a[0] = 16'(y * w + x);
            fp.n = 3'd1;
        end
        else
        begin
            x = ((w - 1) * u) >> FRAC_BITS;
            y = ((h - 1) * v) >> FRAC_BITS;
            c = y * w + x;
            fp.a[0] = 16'(c);
            fp.n = 3'd1;
            if (x > 0)
            begin
                fp.a[fp.n] = 16'(c - 1);
                fp.n = fp.n + 3'd1;
            end
            if (x < w - 1)
            begin
                fp.a[fp.n] = 16'(c + 1);
                fp.n = fp.n + 3'd1;
            end
            if (y > 0)
            begin
                fp.a[fp.n] = 16'(c - w);
                fp.n = fp.n + 3'd1;
            end
            if (y < h - 1)
            begin
                fp.a[fp.n] = 16'(c + w);
                fp.n = fp.n + 3'd1;
            end
        end
        return fp;
    endfunction

    function automatic rgba_t sample_texture(logic [23:0] s, logic [23:0] t);
        footprint_t  fp;
        rgba_t       texel;
        rgba_t       color;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int unsigned sum_a;
        fp = texel_footprint(s, t);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        sum_a = 0;
        for (int k = 0; k < fp.n; k++)
        begin
            texel = texel_mem[fp.a[k]];
            sum_r += texel.red;
            sum_g += texel.green;
            sum_b += texel.blue;
            sum_a += texel.alpha;
        end
        color.red   = 8'(sum_r / fp.n);
        color.green = 8'(sum_g / fp.n);
        color.blue  = 8'(sum_b / fp.n);
        color.alpha = cfg_alpha ? 8'(sum_a / fp.n) : 8'hFF;
        return color;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_cnt++;
    endtask

    task automatic check_channel(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    // input transactions update the texel store or queue the predicted color
    always @(negedge clk)
    begin : input_monitor
        texel_cmd_t    cmd;
        pinned_color_t pin;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            cmd = texel_cmd_t'(s_axis_tdata);
            if (s_axis_tuser == OP_WRITE)
                texel_mem[cmd.index] = cmd.texel;
            else
            begin
                pin = pinned_colors.pop_front();
                if (pin.fixed)
                    expected_colors.push_back(pin.color);
                else
                    expected_colors.push_back(sample_texture(cmd.s, cmd.t));
            end
        end
    end

    always @(negedge clk)
    begin : output_monitor
        rgba_t got;
        rgba_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = rgba_t'(m_axis_tdata);
            colors_seen++;
            if (expected_colors.size() == 0)
                report_error($sformatf("unexpected color %08h", m_axis_tdata));
            else
            begin
                want = expected_colors.pop_front();
                check_channel("red", got.red, want.red);
                check_channel("green", got.green, want.green);
                check_channel("blue", got.blue, want.blue);
                check_channel("alpha", got.alpha, want.alpha);
            end
        end
    end

    task automatic send_item(logic op, texel_cmd_t cmd, logic fixed, rgba_t want);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (op == OP_SAMPLE)
        begin
            pinned_colors.push_back('{fixed, want});
            samples_sent++;
        end
        else
        begin
            texel_known[cmd.index] = 1'b1;
            writes_sent++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        s_axis_tuser  <= op;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    // texels under the sample footprint are written first if still unknown
    task automatic sample_at(logic [23:0] s, logic [23:0] t);
        footprint_t fp;
        texel_cmd_t cmd;
        fp = texel_footprint(s, t);
        for (int k = 0; k < fp.n; k++)
        begin
            if (!texel_known[fp.a[k]])
            begin
                cmd = {$urandom, $urandom, $urandom};
                cmd.index = fp.a[k];
                send_item(OP_WRITE, cmd, 1'b0, '0);
            end
        end
        cmd = {$urandom, $urandom, $urandom};
        cmd.s = s;
        cmd.t = t;
        send_item(OP_SAMPLE, cmd, 1'b0, '0);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 24'($urandom_range(0, 32'h10000));
            1: return {8'($urandom_range(0, 255)), 16'h0000};
            2: return 24'(-$urandom_range(0, 32'h20000));
            3: return 24'($urandom_range(32'h8000, 32'h18000));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FILTER_MODE: cfg_filter = value[0];
            REG_WRAP_S:      cfg_wrap_s = value[0];
            REG_WRAP_T:      cfg_wrap_t = value[0];
            REG_TEX_WIDTH:   cfg_width  = value[8:0];
            REG_TEX_HEIGHT:  cfg_height = value[8:0];
            REG_HAS_ALPHA:   cfg_alpha  = value[0];
            default: ;
        endcase
    endtask

    task automatic program_texture(tex_cfg_t cfg);
        write_reg(REG_FILTER_MODE, 32'(cfg.filter));
        write_reg(REG_WRAP_S, 32'(cfg.wrap_s));
        write_reg(REG_WRAP_T, 32'(cfg.wrap_t));
        write_reg(REG_TEX_WIDTH, 32'(cfg.width));
        write_reg(REG_TEX_HEIGHT, 32'(cfg.height));
        write_reg(REG_HAS_ALPHA, 32'(cfg.alpha));
    endtask

    task automatic run_phase(tex_cfg_t cfg);
        texel_cmd_t cmd;
        program_texture(cfg);
        for (int i = 0; i < EDGE_COORDS; i++)
            sample_at(EDGE_COORD_TBL[i], EDGE_COORD_TBL[(i + 3) % EDGE_COORDS]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                cmd = {$urandom, $urandom, $urandom};
                send_item(OP_WRITE, cmd, 1'b0, '0);
            end
            else if ($urandom_range(0, 5) == 0)
                sample_at(24'($urandom), 24'($urandom));
            else
                sample_at(pick_coord(), pick_coord());
        end
        drain_and_settle();
        phases_run++;
    endtask

    initial
    begin : stimulus
        texel_cmd_t cmd;
        tex_cfg_t   cfg;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            cmd = '0;
            cmd.s     = DIRECTED_TBL[i].s;
            cmd.t     = DIRECTED_TBL[i].t;
            cmd.index = DIRECTED_TBL[i].index;
            cmd.texel = DIRECTED_TBL[i].texel;
            send_item(DIRECTED_TBL[i].op, cmd, DIRECTED_TBL[i].fixed, DIRECTED_TBL[i].want);
        end
        drain_and_settle();

        for (int p = 0; p < FIXED_PHASES; p++)
            run_phase(PHASE_TBL[p]);
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            cfg.filter = 1'($urandom);
            cfg.wrap_s = 1'($urandom);
            cfg.wrap_t = 1'($urandom);
            cfg.width  = 9'($urandom_range(1, 12));
            cfg.height = 9'($urandom_range(1, 12));
            cfg.alpha  = 1'($urandom);
            run_phase(cfg);
        end

        $display("%0d texel writes and %0d samples over %0d texture settings",
                 writes_sent, samples_sent, phases_run + 1);
        $display("%0d colors compared, %0d mismatches", colors_seen, error_cnt);
        if (error_cnt == 0 && expected_colors.size() == 0)
            $display("== PASS ==");
        else
        begin
            if (expected_colors.size() != 0)
                $display("%0d expected colors never arrived", expected_colors.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
